[hw/rtl/tseq_pkg.sv]
// ----------------------------------------------------------------------------
// tseq_pkg: shared types and constants for the tone sequencer
// Request layouts, note entry format, action and register codes, sizes.
// ----------------------------------------------------------------------------
package tseq_pkg;

    // Sizes of the effect slot file and the song memory
    localparam int EFFECT_SLOTS = 5;
    localparam int SONG_DEPTH   = 64;

    localparam int SONG_AW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
    localparam int LEN_W   = $clog2(SONG_DEPTH + 1) + 1;
    localparam int EFF_CW  = $clog2(EFFECT_SLOTS + 1);
    localparam int EFF_IW  = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 7;

    localparam logic [CFG_IW-1:0] CFG_SONG_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SONG_REPEAT = 2'd1;

    localparam logic [6:0] SONG_LENGTH_RST = 7'd38;

    // Action codes
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_SINGLE_TONE = 3'd1;
    localparam logic [2:0] ACT_EFFECT_NOTE = 3'd2;
    localparam logic [2:0] ACT_SONG_START  = 3'd3;
    localparam logic [2:0] ACT_SONG_STOP   = 3'd4;
    localparam logic [2:0] ACT_SONG_WRITE  = 3'd5;

    // One stored note: duration in the upper half, frequency in the lower
    typedef struct packed {
        logic [15:0] duration;
        logic [15:0] freq;
    } note_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [5:0]  slot;
        logic        last_note;
    } in_item_t;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic        sounding;
        logic        effect_active;
        logic [5:0]  song_position;
    } out_item_t;

endpackage

[hw/rtl/tone_sequencer_with_effect_override.sv]
// ----------------------------------------------------------------------------
// tone_sequencer_with_effect_override: buzzer note sequencer
// Plays single tones, staged effect melodies and a background song held in
// a synchronous song memory; effects override the song, which then resumes.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              content
//  -------   ---   ---------------------  -------------------------------
//  s_        in    s_valid / s_ready      in_item_t action request
//  m_        out   m_valid / m_ready      out_item_t tone and status
//  cfg_      in    cfg_valid / cfg_ready  register index and write data
//
//  One request per clock while the output is not stalled. A request is taken
//  into an execute register while the song memory is read (or written) on
//  the same edge; the edge on which the execute stage fires applies the
//  update and loads the output register. The read address is built from the
//  state left by the request still executing, so no bubble is needed.
//  Synchronous active-low reset clears the control state and loads the
//  configuration defaults; memories are not cleared. A stalled output register
//  holds the execute stage and drops s_ready; cfg_ready is always high.
//
module tone_sequencer_with_effect_override (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tseq_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tseq_pkg::out_item_t         m_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tseq_pkg::CFG_IW-1:0] cfg_index,
    input  logic [tseq_pkg::CFG_DW-1:0] cfg_data
);
    import tseq_pkg::*;

    // Configuration
    logic [6:0]        song_length_reg;
    logic              song_repeat_reg;
    logic [LEN_W-1:0]  len_eff;

    // Pipeline control
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    out_item_t         out_next;
    logic              accept;
    logic              exec_fire;

    // Sequencer state
    logic [EFF_CW-1:0]  count_reg,     count_next;
    logic [EFF_IW-1:0]  eidx_reg,      eidx_next;
    logic [15:0]        time_left_reg, time_next;
    logic               running_reg,   running_next;
    logic               song_en_reg,   song_en_next;
    logic [SONG_AW-1:0] song_idx_reg,  song_idx_next;
    logic [15:0]        drive_reg,     drive_next;
    note_t              staged_reg [EFFECT_SLOTS];
    note_t              staged_next [EFFECT_SLOTS];
    note_t              effect_reg [EFFECT_SLOTS];
    note_t              effect_next [EFFECT_SLOTS];

    // Song memory
    note_t              song_mem [SONG_DEPTH];
    note_t              song_rd_reg;
    logic               mem_we;
    logic [SONG_AW-1:0] mem_addr;
    logic [SONG_AW-1:0] rd_addr;
    logic [LEN_W-1:0]   rd_inc;

    // Execute helpers
    logic               do_start;
    logic               do_silence;
    note_t              start_note;
    note_t              req_note;
    logic [15:0]        tl_dec;
    logic [EFF_CW-1:0]  eidx_inc;
    logic [LEN_W-1:0]   song_inc;
    logic [EFF_CW-1:0]  commit_len;

    // Handshake
    assign exec_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || exec_fire;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    // Song length clamped to 1..SONG_DEPTH
    always_comb begin
        if (song_length_reg == 7'd0) begin
            len_eff = LEN_W'(1);
        end else if (32'(song_length_reg) > SONG_DEPTH) begin
            len_eff = LEN_W'(SONG_DEPTH);
        end else begin
            len_eff = LEN_W'(song_length_reg);
        end
    end

    // Next state for the request in the execute register
    always_comb begin
        count_next    = count_reg;
        eidx_next     = eidx_reg;
        time_next     = time_left_reg;
        running_next  = running_reg;
        song_en_next  = song_en_reg;
        song_idx_next = song_idx_reg;
        drive_next    = drive_reg;
        staged_next   = staged_reg;
        effect_next   = effect_reg;
        do_start      = 1'b0;
        do_silence    = 1'b0;
        start_note    = song_rd_reg;

        req_note   = '{duration: s1_item_reg.note_duration, freq: s1_item_reg.note_freq};
        tl_dec     = (time_left_reg != 16'd0) ? time_left_reg - 16'd1 : 16'd0;
        eidx_inc   = EFF_CW'(eidx_reg) + EFF_CW'(1);
        song_inc   = LEN_W'(song_idx_reg) + LEN_W'(1);
        commit_len = (32'(s1_item_reg.slot) >= EFFECT_SLOTS) ? EFF_CW'(EFFECT_SLOTS)
                                                             : EFF_CW'(s1_item_reg.slot) + EFF_CW'(1);

        if (exec_fire) begin
            case (s1_item_reg.action)
                ACT_TICK: begin
                    if (running_reg) begin
                        time_next = tl_dec;
                        if (tl_dec == 16'd0) begin
                            if (count_reg != '0) begin
                                // next effect note, or hand back to the song, or fall silent if it is off
                                if (eidx_inc < count_reg) begin
                                    eidx_next  = eidx_inc[EFF_IW-1:0];
                                    start_note = effect_reg[eidx_inc[EFF_IW-1:0]];
                                    do_start   = 1'b1;
                                end else begin
                                    count_next = '0;
                                    do_start   = song_en_reg;
                                    do_silence = !song_en_reg;
                                end
                            end else if (song_en_reg) begin
                                // advance the song, wrapping or stopping at its end
                                if (song_inc >= len_eff) begin
                                    if (song_repeat_reg) begin
                                        song_idx_next = '0;
                                        do_start      = 1'b1;
                                    end else begin
                                        song_en_next  = 1'b0;
                                        song_idx_next = SONG_AW'(song_inc);
                                        do_silence    = 1'b1;
                                    end
                                end else begin
                                    song_idx_next = SONG_AW'(song_inc);
                                    do_start      = 1'b1;
                                end
                            end else begin
                                do_silence = 1'b1;
                            end
                        end
                    end
                end
                ACT_SINGLE_TONE: begin
                    count_next = '0;
                    start_note = req_note;
                    do_start   = 1'b1;
                end
                ACT_EFFECT_NOTE: begin
                    if (32'(s1_item_reg.slot) < EFFECT_SLOTS) begin
                        staged_next[EFF_IW'(s1_item_reg.slot)] = req_note;
                    end
                    // last note commits the staged melody
                    if (s1_item_reg.last_note) begin
                        for (int i = 0; i < EFFECT_SLOTS; i++) begin
                            if (i < int'(commit_len)) begin
                                effect_next[i] = staged_next[i];
                            end
                        end
                        count_next = commit_len;
                        eidx_next  = '0;
                        start_note = staged_next[0];
                        do_start   = 1'b1;
                    end
                end
                ACT_SONG_START: begin
                    song_en_next  = 1'b1;
                    song_idx_next = '0;
                    do_start      = (count_reg == '0);
                end
                ACT_SONG_STOP: begin
                    song_en_next = 1'b0;
                    do_silence   = (count_reg == '0);
                end
                default: begin
                end
            endcase
        end

        if (do_start) begin
            drive_next   = start_note.freq;
            time_next    = start_note.duration;
            running_next = 1'b1;
        end else if (do_silence) begin
            drive_next   = 16'd0;
            running_next = 1'b0;
        end
    end

    // Song memory address: the entry the incoming request may play, or the entry a song write targets
    always_comb begin
        rd_inc = LEN_W'(song_idx_next) + LEN_W'(1);
        mem_we = (s_item.action == ACT_SONG_WRITE) && (32'(s_item.slot) < SONG_DEPTH);
        if (s_item.action == ACT_SONG_START) begin
            rd_addr = '0;
        end else if (count_next != '0) begin
            rd_addr = song_idx_next;
        end else if (rd_inc >= len_eff) begin
            rd_addr = '0;
        end else begin
            rd_addr = SONG_AW'(rd_inc);
        end
        mem_addr = mem_we ? SONG_AW'(s_item.slot) : rd_addr;
    end

    // Single-port song memory, accessed on acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (mem_we) begin
                song_mem[mem_addr] <= '{duration: s_item.note_duration, freq: s_item.note_freq};
            end else begin
                song_rd_reg <= song_mem[mem_addr];
            end
        end
    end

    // Result of the executing request
    always_comb begin
        out_next = '{tone_freq:     drive_next,
                     sounding:      running_next,
                     effect_active: (count_next != '0),
                     song_position: 6'(32'(song_idx_next))};
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        staged_reg <= staged_next;
        effect_reg <= effect_next;
        if (accept) begin
            s1_item_reg <= s_item;
        end
        if (exec_fire) begin
            m_item_reg <= out_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            count_reg       <= '0;
            eidx_reg        <= '0;
            time_left_reg   <= 16'd0;
            running_reg     <= 1'b0;
            song_en_reg     <= 1'b0;
            song_idx_reg    <= '0;
            drive_reg       <= 16'd0;
            song_length_reg <= SONG_LENGTH_RST;
            song_repeat_reg <= 1'b1;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            count_reg     <= count_next;
            eidx_reg      <= eidx_next;
            time_left_reg <= time_next;
            running_reg   <= running_next;
            song_en_reg   <= song_en_next;
            song_idx_reg  <= song_idx_next;
            drive_reg     <= drive_next;
            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SONG_LENGTH: song_length_reg <= cfg_data[6:0];
                    CFG_SONG_REPEAT: song_repeat_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // effect length never exceeds the slot file
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= EFFECT_SLOTS)
        else $error("effect count beyond slot count");

    // the playing effect note lies inside the committed melody
    a_eidx_in_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (EFF_CW'(eidx_reg) < count_reg))
        else $error("effect index outside committed melody");

    // nothing is driven without a running note
    a_silent_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (drive_reg == 16'd0))
        else $error("buzzer driven with no running note");

    // an accepted request always lands in the execute register
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request lost");

    // a blocked execute stage keeps its request
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !exec_fire) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled request changed");
`endif

endmodule
